/* sv/tpsc_pkg.sv */
package tpsc_pkg;

   // Field widths
   localparam int RAW_W = 16;
   localparam int OUT_W = 24;

   // Calibration point widths and Q8 scaling (value/k * 256 = value << shift)
   localparam int TEMP_POINT_W     = 10;
   localparam int TEMP_SCALE_SHIFT = 5;
   localparam int HUM_POINT_W      = 8;
   localparam int HUM_SCALE_SHIFT  = 7;

   // Quotient bits resolved per divider stage
   localparam int DIV_STEP = 4;

   // Saturation limits
   localparam logic signed [OUT_W-1:0] Q8_MAX = 24'sh7FFFFF;
   localparam logic signed [OUT_W-1:0] Q8_MIN = 24'sh800000;

   // Register map
   typedef enum logic [2:0] {
      CSR_HUM_POINT0  = 3'd0,
      CSR_HUM_POINT1  = 3'd1,
      CSR_TEMP_POINT0 = 3'd2,
      CSR_TEMP_POINT1 = 3'd3,
      CSR_HUM_RAW0    = 3'd4,
      CSR_HUM_RAW1    = 3'd5,
      CSR_TEMP_RAW0   = 3'd6,
      CSR_TEMP_RAW1   = 3'd7
   } csr_index_type;

   // Per-channel status leaving the channel pipeline
   typedef struct packed {
      logic valid;
      logic cal_error;
   } chan_status_type;

endpackage

/* sv/tpsc_chan.sv */
// One compensation channel: difference, multiply, magnitude, pipelined
// restoring divide (DIV_STEP quotient bits per stage), offset add and saturate.
module tpsc_chan #(
   parameter int POINT_W     = 10,
   parameter int SCALE_SHIFT = 5
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   enable,
   input  logic                                   in_valid,
   input  logic [POINT_W-1:0]                     point0,
   input  logic [POINT_W-1:0]                     point1,
   input  logic signed [tpsc_pkg::RAW_W-1:0]      raw0,
   input  logic signed [tpsc_pkg::RAW_W-1:0]      raw1,
   input  logic signed [tpsc_pkg::RAW_W-1:0]      sample,
   output logic signed [tpsc_pkg::OUT_W-1:0]      value,
   output tpsc_pkg::chan_status_type              status
);

   localparam int RW     = tpsc_pkg::RAW_W;
   localparam int OW     = tpsc_pkg::OUT_W;
   localparam int STEP   = tpsc_pkg::DIV_STEP;
   localparam int DIFF_W = RW + 1;
   localparam int DP_W   = POINT_W + 1;
   localparam int PROD_W = DP_W + DIFF_W;
   localparam int MAG_W  = POINT_W + RW;
   localparam int QW     = MAG_W + SCALE_SHIFT;
   localparam int NDIV   = (QW + STEP - 1) / STEP;
   localparam int PW     = NDIV * STEP;
   localparam int SUM_W  = PW + 2;

   // One divider stage: STEP restoring steps on the partial remainder
   function automatic logic [RW+PW-1:0] div_stage(input logic [RW-1:0] rem_i,
                                                  input logic [PW-1:0] work_i,
                                                  input logic [RW-1:0] dvs);
      logic [RW:0]   trial;
      logic [RW-1:0] r;
      logic [PW-1:0] w;
      r = rem_i;
      w = work_i;
      for (int j = 0; j < STEP; j++) begin
         trial = {r, w[PW-1]};
         w     = {w[PW-2:0], 1'b0};
         if (trial >= {1'b0, dvs}) begin
            trial = trial - {1'b0, dvs};
            w[0]  = 1'b1;
         end
         r = trial[RW-1:0];
      end
      return {r, w};
   endfunction

   // Stage 1: differences
   logic signed [DP_W-1:0]   dp_ff, dp_in;
   logic signed [DIFF_W-1:0] draw_ff, draw_in;
   logic signed [DIFF_W-1:0] den_ff, den_in;
   logic                     v1_ff, v1_in;

   // Stage 2: product, divisor magnitude
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [RW-1:0]            dmag_ff, dmag_in;
   logic                     dneg_ff, dneg_in;
   logic                     dzero_ff, dzero_in;
   logic                     v2_ff, v2_in;

   // Divider stages; index 0 holds the scaled dividend magnitude
   logic [PW-1:0] work_ff [0:NDIV];
   logic [PW-1:0] work_in [0:NDIV];
   logic [RW-1:0] rem_ff  [0:NDIV];
   logic [RW-1:0] rem_in  [0:NDIV];
   logic [RW-1:0] dvs_ff  [0:NDIV];
   logic [RW-1:0] dvs_in  [0:NDIV];
   logic          neg_ff  [0:NDIV];
   logic          neg_in  [0:NDIV];
   logic          zero_ff [0:NDIV];
   logic          zero_in [0:NDIV];
   logic          vld_ff  [0:NDIV];
   logic          vld_in  [0:NDIV];

   // Output stage
   logic signed [OW-1:0] value_ff, value_in;
   logic                 err_ff, err_in;
   logic                 vout_ff, vout_in;

   logic [DIFF_W-1:0]       den_abs;
   logic [PROD_W-1:0]       prod_abs;
   logic signed [SUM_W-1:0] q_ext;
   logic signed [SUM_W-1:0] q_signed;
   logic signed [SUM_W-1:0] base;
   logic signed [SUM_W-1:0] sum;
   logic [SUM_W-OW:0]       sum_hi;

   // Stage 1
   always_comb begin
      dp_in   = $signed({1'b0, point1}) - $signed({1'b0, point0});
      draw_in = $signed({sample[RW-1], sample}) - $signed({raw0[RW-1], raw0});
      den_in  = $signed({raw1[RW-1], raw1}) - $signed({raw0[RW-1], raw0});
      v1_in   = in_valid;
   end

   // Stage 2
   always_comb begin
      prod_in  = dp_ff * draw_ff;
      den_abs  = den_ff[DIFF_W-1] ? DIFF_W'(-den_ff) : DIFF_W'(den_ff);
      dmag_in  = den_abs[RW-1:0];
      dneg_in  = den_ff[DIFF_W-1];
      dzero_in = (den_ff == '0);
      v2_in    = v1_ff;
   end

   // Stage 3 and divider stages
   always_comb begin
      prod_abs   = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      work_in[0] = PW'({prod_abs[MAG_W-1:0], {SCALE_SHIFT{1'b0}}});
      rem_in[0]  = '0;
      dvs_in[0]  = dmag_ff;
      neg_in[0]  = prod_ff[PROD_W-1] ^ dneg_ff;
      zero_in[0] = dzero_ff;
      vld_in[0]  = v2_ff;
      for (int k = 1; k <= NDIV; k++) begin
         {rem_in[k], work_in[k]} = div_stage(rem_ff[k-1], work_ff[k-1], dvs_ff[k-1]);
         dvs_in[k]  = dvs_ff[k-1];
         neg_in[k]  = neg_ff[k-1];
         zero_in[k] = zero_ff[k-1];
         vld_in[k]  = vld_ff[k-1];
      end
   end

   // Output stage: apply sign, add point 0 offset, saturate; zero on a calibration error
   always_comb begin
      q_ext    = $signed({2'b00, work_ff[NDIV]});
      q_signed = neg_ff[NDIV] ? -q_ext : q_ext;
      base     = $signed(SUM_W'({point0, {SCALE_SHIFT{1'b0}}}));
      sum      = base + q_signed;
      sum_hi   = sum[SUM_W-1:OW-1];
      if (zero_ff[NDIV]) begin
         value_in = '0;
      end else if ((&sum_hi) || !(|sum_hi)) begin
         value_in = sum[OW-1:0];
      end else begin
         value_in = sum[SUM_W-1] ? tpsc_pkg::Q8_MIN : tpsc_pkg::Q8_MAX;
      end
      err_in  = zero_ff[NDIV];
      vout_in = vld_ff[NDIV];
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         vout_ff <= 1'b0;
         for (int k = 0; k <= NDIV; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (enable) begin
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         vout_ff <= vout_in;
         for (int k = 0; k <= NDIV; k++) begin
            vld_ff[k] <= vld_in[k];
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (enable) begin
         dp_ff    <= dp_in;
         draw_ff  <= draw_in;
         den_ff   <= den_in;
         prod_ff  <= prod_in;
         dmag_ff  <= dmag_in;
         dneg_ff  <= dneg_in;
         dzero_ff <= dzero_in;
         for (int k = 0; k <= NDIV; k++) begin
            work_ff[k] <= work_in[k];
            rem_ff[k]  <= rem_in[k];
            dvs_ff[k]  <= dvs_in[k];
            neg_ff[k]  <= neg_in[k];
            zero_ff[k] <= zero_in[k];
         end
         value_ff <= value_in;
         err_ff   <= err_in;
      end
   end

   assign value            = value_ff;
   assign status.valid     = vout_ff;
   assign status.cal_error = err_ff;

endmodule

/* sv/two_point_sensor_compensation.sv */
// Two-point sensor compensation. Each accepted beat carries one raw
// temperature and one raw humidity sample; each is interpolated linearly
// between two calibration points (csr indexes 0..7) and returned in Q8 with
// saturation to 24 bits. A channel whose two raw calibration points are equal
// returns zero with its cal_error flag set. One beat is accepted per cycle
// while the output is not stalled; a request passes three front stages, an
// 8-stage divider resolving 4 quotient bits per stage and one output stage.
// The output stage is the result register: while it holds an untaken beat
// the whole pipeline stalls and req_ready is low. Write calibration
// registers only while no beat is in flight.
module two_point_sensor_compensation (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [tpsc_pkg::RAW_W-1:0]   req_raw_temp,
   input  logic signed [tpsc_pkg::RAW_W-1:0]   req_raw_hum,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tpsc_pkg::OUT_W-1:0]   rsp_temp_q8,
   output logic signed [tpsc_pkg::OUT_W-1:0]   rsp_hum_q8,
   output logic                                rsp_temp_cal_error,
   output logic                                rsp_hum_cal_error,
   input  logic                                csr_write_en,
   input  logic [2:0]                          csr_index,
   input  logic [tpsc_pkg::RAW_W-1:0]          csr_wdata
);

   localparam int RW = tpsc_pkg::RAW_W;

   // Calibration registers
   logic [tpsc_pkg::HUM_POINT_W-1:0]  hum_point0_ff, hum_point1_ff;
   logic [tpsc_pkg::TEMP_POINT_W-1:0] temp_point0_ff, temp_point1_ff;
   logic signed [RW-1:0]              hum_raw0_ff, hum_raw1_ff;
   logic signed [RW-1:0]              temp_raw0_ff, temp_raw1_ff;

   logic                      advance;
   tpsc_pkg::chan_status_type t_stat;
   tpsc_pkg::chan_status_type h_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         hum_point0_ff  <= '0;
         hum_point1_ff  <= '0;
         temp_point0_ff <= '0;
         temp_point1_ff <= '0;
         hum_raw0_ff    <= '0;
         hum_raw1_ff    <= '0;
         temp_raw0_ff   <= '0;
         temp_raw1_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            tpsc_pkg::CSR_HUM_POINT0: begin
               hum_point0_ff <= csr_wdata[tpsc_pkg::HUM_POINT_W-1:0];
            end
            tpsc_pkg::CSR_HUM_POINT1: begin
               hum_point1_ff <= csr_wdata[tpsc_pkg::HUM_POINT_W-1:0];
            end
            tpsc_pkg::CSR_TEMP_POINT0: begin
               temp_point0_ff <= csr_wdata[tpsc_pkg::TEMP_POINT_W-1:0];
            end
            tpsc_pkg::CSR_TEMP_POINT1: begin
               temp_point1_ff <= csr_wdata[tpsc_pkg::TEMP_POINT_W-1:0];
            end
            tpsc_pkg::CSR_HUM_RAW0:  hum_raw0_ff  <= $signed(csr_wdata);
            tpsc_pkg::CSR_HUM_RAW1:  hum_raw1_ff  <= $signed(csr_wdata);
            tpsc_pkg::CSR_TEMP_RAW0: temp_raw0_ff <= $signed(csr_wdata);
            tpsc_pkg::CSR_TEMP_RAW1: temp_raw1_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // Pipeline moves whenever the result register is free or being taken
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   tpsc_chan #(
      .POINT_W     (tpsc_pkg::TEMP_POINT_W),
      .SCALE_SHIFT (tpsc_pkg::TEMP_SCALE_SHIFT)
   ) u_temp (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (req_valid),
      .point0   (temp_point0_ff),
      .point1   (temp_point1_ff),
      .raw0     (temp_raw0_ff),
      .raw1     (temp_raw1_ff),
      .sample   (req_raw_temp),
      .value    (rsp_temp_q8),
      .status   (t_stat)
   );

   tpsc_chan #(
      .POINT_W     (tpsc_pkg::HUM_POINT_W),
      .SCALE_SHIFT (tpsc_pkg::HUM_SCALE_SHIFT)
   ) u_hum (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_valid (req_valid),
      .point0   (hum_point0_ff),
      .point1   (hum_point1_ff),
      .raw0     (hum_raw0_ff),
      .raw1     (hum_raw1_ff),
      .sample   (req_raw_hum),
      .value    (rsp_hum_q8),
      .status   (h_stat)
   );

   assign rsp_valid          = t_stat.valid;
   assign rsp_temp_cal_error = t_stat.cal_error;
   assign rsp_hum_cal_error  = h_stat.cal_error;

   // Both channel pipelines must stay in lockstep
   a_chan_aligned: assert property (@(posedge clock) disable iff (reset)
      t_stat.valid == h_stat.valid)
      else $error("channel pipelines out of step");

   // A calibration error forces a zero value
   a_temp_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_temp_cal_error |-> rsp_temp_q8 == '0)
      else $error("temperature error beat carries nonzero value");

   a_hum_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hum_cal_error |-> rsp_hum_q8 == '0)
      else $error("humidity error beat carries nonzero value");

   // A beat stuck at the output keeps the pipeline frozen
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && !$past(req_ready))
      else $error("pipeline advanced under a held beat");

endmodule

/* sim/two_point_sensor_compensation_test.sv */
module two_point_sensor_compensation_test;

   localparam int PIPE_LATENCY = 12;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct {
      logic signed [tpsc_pkg::OUT_W-1:0] temp_q8;
      logic signed [tpsc_pkg::OUT_W-1:0] hum_q8;
      logic                              temp_cal_error;
      logic                              hum_cal_error;
   } compensated_sample_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic signed [tpsc_pkg::RAW_W-1:0] req_raw_temp;
   logic signed [tpsc_pkg::RAW_W-1:0] req_raw_hum;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic signed [tpsc_pkg::OUT_W-1:0] rsp_temp_q8;
   logic signed [tpsc_pkg::OUT_W-1:0] rsp_hum_q8;
   logic                              rsp_temp_cal_error;
   logic                              rsp_hum_cal_error;
   logic                              csr_write_en;
   logic [2:0]                        csr_index;
   logic [tpsc_pkg::RAW_W-1:0]        csr_wdata;

   // Mirror of the calibration registers
   logic [tpsc_pkg::HUM_POINT_W-1:0]  cal_hum_point0;
   logic [tpsc_pkg::HUM_POINT_W-1:0]  cal_hum_point1;
   logic [tpsc_pkg::TEMP_POINT_W-1:0] cal_temp_point0;
   logic [tpsc_pkg::TEMP_POINT_W-1:0] cal_temp_point1;
   logic signed [tpsc_pkg::RAW_W-1:0] cal_hum_raw0;
   logic signed [tpsc_pkg::RAW_W-1:0] cal_hum_raw1;
   logic signed [tpsc_pkg::RAW_W-1:0] cal_temp_raw0;
   logic signed [tpsc_pkg::RAW_W-1:0] cal_temp_raw1;

   compensated_sample_type pending_samples[$];
   int                     error_count = 0;
   int                     cycle_count = 0;
   int                     send_idle_pct;
   int                     recv_idle_pct;

   two_point_sensor_compensation dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_raw_temp       (req_raw_temp),
      .req_raw_hum        (req_raw_hum),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_temp_q8        (rsp_temp_q8),
      .rsp_hum_q8         (rsp_hum_q8),
      .rsp_temp_cal_error (rsp_temp_cal_error),
      .rsp_hum_cal_error  (rsp_hum_cal_error),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #6 clock = ~clock;

   // One channel: linear interpolation in Q8, truncating division, saturation
   function automatic void interpolate_q8(input longint p0, input longint p1,
                                          input longint r0, input longint r1,
                                          input longint raw, input int shift,
                                          output logic signed [tpsc_pkg::OUT_W-1:0] q8,
                                          output logic cal_error);
      longint den;
      longint scale;
      longint v;
      den   = r1 - r0;
      scale = longint'(1) <<< shift;
      if (den == 0) begin
         cal_error = 1'b1;
         q8        = '0;
      end else begin
         cal_error = 1'b0;
         v = p0 * scale + ((p1 - p0) * (raw - r0) * scale) / den;
         if (v > longint'(tpsc_pkg::Q8_MAX)) v = longint'(tpsc_pkg::Q8_MAX);
         if (v < longint'(tpsc_pkg::Q8_MIN)) v = longint'(tpsc_pkg::Q8_MIN);
         q8 = v[tpsc_pkg::OUT_W-1:0];
      end
   endfunction

   function automatic compensated_sample_type compensate(
         logic signed [tpsc_pkg::RAW_W-1:0] raw_temp,
         logic signed [tpsc_pkg::RAW_W-1:0] raw_hum);
      compensated_sample_type s;
      interpolate_q8(longint'(cal_temp_point0), longint'(cal_temp_point1),
                     longint'(cal_temp_raw0), longint'(cal_temp_raw1),
                     longint'(raw_temp), tpsc_pkg::TEMP_SCALE_SHIFT,
                     s.temp_q8, s.temp_cal_error);
      interpolate_q8(longint'(cal_hum_point0), longint'(cal_hum_point1),
                     longint'(cal_hum_raw0), longint'(cal_hum_raw1),
                     longint'(raw_hum), tpsc_pkg::HUM_SCALE_SHIFT,
                     s.hum_q8, s.hum_cal_error);
      return s;
   endfunction

   // Register write, one cycle, mirrored with the same masking as the block
   task automatic write_csr(tpsc_pkg::csr_index_type idx,
                            logic [tpsc_pkg::RAW_W-1:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = value;
      case (idx)
         tpsc_pkg::CSR_HUM_POINT0:  cal_hum_point0  = value[tpsc_pkg::HUM_POINT_W-1:0];
         tpsc_pkg::CSR_HUM_POINT1:  cal_hum_point1  = value[tpsc_pkg::HUM_POINT_W-1:0];
         tpsc_pkg::CSR_TEMP_POINT0: cal_temp_point0 = value[tpsc_pkg::TEMP_POINT_W-1:0];
         tpsc_pkg::CSR_TEMP_POINT1: cal_temp_point1 = value[tpsc_pkg::TEMP_POINT_W-1:0];
         tpsc_pkg::CSR_HUM_RAW0:    cal_hum_raw0    = value;
         tpsc_pkg::CSR_HUM_RAW1:    cal_hum_raw1    = value;
         tpsc_pkg::CSR_TEMP_RAW0:   cal_temp_raw0   = value;
         tpsc_pkg::CSR_TEMP_RAW1:   cal_temp_raw1   = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Send one sample pair; valid stays up after the beat until the next negedge
   task automatic send_sample(logic signed [tpsc_pkg::RAW_W-1:0] raw_temp,
                              logic signed [tpsc_pkg::RAW_W-1:0] raw_hum);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid    = 1'b1;
      req_raw_temp = raw_temp;
      req_raw_hum  = raw_hum;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_samples.push_back(compensate(raw_temp, raw_hum));
   endtask

   // Drop valid and let every outstanding beat come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Random raw calibration pair: equal, very close, full span or anything
   task automatic pick_raw_points(output logic signed [tpsc_pkg::RAW_W-1:0] r0,
                                  output logic signed [tpsc_pkg::RAW_W-1:0] r1);
      int mode;
      int delta;
      mode  = $urandom_range(7);
      delta = int'($urandom_range(4, 1));
      if ($urandom_range(1) == 1) delta = -delta;
      r0    = tpsc_pkg::RAW_W'($urandom);
      case (mode)
         0: r1 = r0;
         1: r1 = r0 + tpsc_pkg::RAW_W'(delta);
         2: begin
            r0 = $urandom_range(1) ? 16'sh8000 : 16'sh7FFF;
            r1 = ~r0;
         end
         default: r1 = tpsc_pkg::RAW_W'($urandom);
      endcase
   endtask

   task automatic randomize_calibration();
      logic signed [tpsc_pkg::RAW_W-1:0] r0;
      logic signed [tpsc_pkg::RAW_W-1:0] r1;
      // upper data bits are random to exercise masking of narrow registers
      write_csr(tpsc_pkg::CSR_HUM_POINT0,
                $urandom_range(3) == 0 ? 16'hFFFF : tpsc_pkg::RAW_W'($urandom));
      write_csr(tpsc_pkg::CSR_HUM_POINT1,
                $urandom_range(3) == 0 ? 16'h0000 : tpsc_pkg::RAW_W'($urandom));
      write_csr(tpsc_pkg::CSR_TEMP_POINT0,
                $urandom_range(3) == 0 ? 16'h0000 : tpsc_pkg::RAW_W'($urandom));
      write_csr(tpsc_pkg::CSR_TEMP_POINT1,
                $urandom_range(3) == 0 ? 16'hFFFF : tpsc_pkg::RAW_W'($urandom));
      pick_raw_points(r0, r1);
      write_csr(tpsc_pkg::CSR_HUM_RAW0, r0);
      write_csr(tpsc_pkg::CSR_HUM_RAW1, r1);
      pick_raw_points(r0, r1);
      write_csr(tpsc_pkg::CSR_TEMP_RAW0, r0);
      write_csr(tpsc_pkg::CSR_TEMP_RAW1, r1);
   endtask

   // Mostly near the calibration span, sometimes anywhere
   function automatic logic signed [tpsc_pkg::RAW_W-1:0] pick_raw(
         logic signed [tpsc_pkg::RAW_W-1:0] r0,
         logic signed [tpsc_pkg::RAW_W-1:0] r1);
      int lo;
      int hi;
      int v;
      if ($urandom_range(9) < 3) return tpsc_pkg::RAW_W'($urandom);
      lo = (r0 < r1) ? int'(r0) : int'(r1);
      hi = (r0 < r1) ? int'(r1) : int'(r0);
      v  = lo - 64 + int'($urandom_range(hi - lo + 128));
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[tpsc_pkg::RAW_W-1:0];
   endfunction

   // All registers are zero after reset: both channels flag an error
   task automatic test_reset_defaults();
      send_sample(16'sh0000, 16'sh0000);
      send_sample(16'sh8000, 16'sh7FFF);
      wait_idle();
   endtask

   // Full raw span, full point span, descending humidity points and raw points, masked writes
   task automatic test_field_extremes();
      write_csr(tpsc_pkg::CSR_TEMP_POINT0, 16'h0000);
      write_csr(tpsc_pkg::CSR_TEMP_POINT1, 16'hFFFF);
      write_csr(tpsc_pkg::CSR_TEMP_RAW0,   16'h8000);
      write_csr(tpsc_pkg::CSR_TEMP_RAW1,   16'h7FFF);
      write_csr(tpsc_pkg::CSR_HUM_POINT0,  16'hFFFF);
      write_csr(tpsc_pkg::CSR_HUM_POINT1,  16'hFF00);
      write_csr(tpsc_pkg::CSR_HUM_RAW0,    16'h7FFF);
      write_csr(tpsc_pkg::CSR_HUM_RAW1,    16'h8000);
      send_sample(16'sh8000, 16'sh8000);
      send_sample(16'sh7FFF, 16'sh7FFF);
      send_sample(16'sh0000, 16'sh0000);
      send_sample(16'shFFFF, 16'sh0001);
      wait_idle();
   endtask

   // Steep slopes push both channels past the 24-bit range both ways
   task automatic test_saturation();
      write_csr(tpsc_pkg::CSR_TEMP_POINT0, 16'h0000);
      write_csr(tpsc_pkg::CSR_TEMP_POINT1, 16'h03FF);
      write_csr(tpsc_pkg::CSR_TEMP_RAW0,   16'h0000);
      write_csr(tpsc_pkg::CSR_TEMP_RAW1,   16'h0001);
      write_csr(tpsc_pkg::CSR_HUM_POINT0,  16'h0000);
      write_csr(tpsc_pkg::CSR_HUM_POINT1,  16'h00FF);
      write_csr(tpsc_pkg::CSR_HUM_RAW0,    16'h0000);
      write_csr(tpsc_pkg::CSR_HUM_RAW1,    16'hFFFF);
      send_sample(16'sh7FFF, 16'sh7FFF);
      send_sample(16'sh8000, 16'sh8000);
      send_sample(16'sh0001, -16'sd1);
      send_sample(16'sh0002, -16'sd2);
      wait_idle();
   endtask

   // Equal raw points on one channel must not disturb the other
   task automatic test_equal_raw_points();
      write_csr(tpsc_pkg::CSR_TEMP_POINT0, 16'h0100);
      write_csr(tpsc_pkg::CSR_TEMP_POINT1, 16'h0200);
      write_csr(tpsc_pkg::CSR_TEMP_RAW0,   16'd100);
      write_csr(tpsc_pkg::CSR_TEMP_RAW1,   16'd100);
      write_csr(tpsc_pkg::CSR_HUM_POINT0,  16'h0040);
      write_csr(tpsc_pkg::CSR_HUM_POINT1,  16'h00A0);
      write_csr(tpsc_pkg::CSR_HUM_RAW0,    16'hF000);
      write_csr(tpsc_pkg::CSR_HUM_RAW1,    16'h1000);
      send_sample(16'sd100, 16'sh0000);
      send_sample(16'sh1234, 16'sh0800);
      wait_idle();
      write_csr(tpsc_pkg::CSR_TEMP_RAW1,   16'd900);
      write_csr(tpsc_pkg::CSR_HUM_RAW1,    16'hF000);
      send_sample(16'sd500, 16'shF000);
      send_sample(16'sh8000, 16'sh7FFF);
      wait_idle();
   endtask

   // Random samples under a fresh calibration every block of beats
   task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
      logic signed [tpsc_pkg::RAW_W-1:0] raw_temp;
      logic signed [tpsc_pkg::RAW_W-1:0] raw_hum;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < n_items; i++) begin
         if (i % 50 == 0) begin
            wait_idle();
            randomize_calibration();
         end
         raw_temp = pick_raw(cal_temp_raw0, cal_temp_raw1);
         raw_hum  = pick_raw(cal_hum_raw0, cal_hum_raw1);
         send_sample(raw_temp, raw_hum);
      end
      wait_idle();
   endtask

   // Receiver stalls
   always @(negedge clock) begin
      rsp_ready = !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Result checker
   always @(posedge clock) begin
      compensated_sample_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0) begin
            $display("%0t unexpected result beat: expected none, actual temp %0d hum %0d",
                     $time, rsp_temp_q8, rsp_hum_q8);
            error_count++;
         end else begin
            want = pending_samples.pop_front();
            if (rsp_temp_q8 !== want.temp_q8) begin
               $display("%0t temp_q8 mismatch: expected %0d actual %0d",
                        $time, want.temp_q8, rsp_temp_q8);
               error_count++;
            end
            if (rsp_hum_q8 !== want.hum_q8) begin
               $display("%0t hum_q8 mismatch: expected %0d actual %0d",
                        $time, want.hum_q8, rsp_hum_q8);
               error_count++;
            end
            if (rsp_temp_cal_error !== want.temp_cal_error) begin
               $display("%0t temp_cal_error mismatch: expected %0b actual %0b",
                        $time, want.temp_cal_error, rsp_temp_cal_error);
               error_count++;
            end
            if (rsp_hum_cal_error !== want.hum_cal_error) begin
               $display("%0t hum_cal_error mismatch: expected %0b actual %0b",
                        $time, want.hum_cal_error, rsp_hum_cal_error);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, pending_samples.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_raw_temp    = '0;
      req_raw_hum     = '0;
      csr_write_en    = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      cal_hum_point0  = '0;
      cal_hum_point1  = '0;
      cal_temp_point0 = '0;
      cal_temp_point1 = '0;
      cal_hum_raw0    = '0;
      cal_hum_raw1    = '0;
      cal_temp_raw0   = '0;
      cal_temp_raw1   = '0;
      send_idle_pct   = 8;
      recv_idle_pct   = 82;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_saturation();
      test_equal_raw_points();
      test_random_traffic(334, 8, 82);
      test_random_traffic(334, 82, 8);
      test_random_traffic(334, 0, 0);

      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (error_count == 0 && pending_samples.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* files.f */
sv/tpsc_pkg.sv
sv/tpsc_chan.sv
sv/two_point_sensor_compensation.sv
sim/two_point_sensor_compensation_test.sv
